FILE: rtl/ucd_pkg.sv
// Shared constants for the undirected cycle detector.
// No dependencies; used by the top level.
package ucd_pkg;

  // Vertex id width, fixed by the edge word format.
  localparam int unsigned VID_W = 8;

  // Vertex count register width and its value after reset.
  localparam int unsigned VCNT_W = 9;
  localparam logic [VCNT_W-1:0] VCNT_RESET = 9'd256;

endpackage

FILE: rtl/ucd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ucd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/undirected_cycle_detector.sv
// Top level of the undirected cycle detector: edge loader and walk sequencer.
// Depends on ucd_pkg and three ucd_ram instances (edges, visited map, stack).
//
//  channel | direction | ports                                         | word
//  in      | input     | in_valid/in_ready, in_edge_*, in_last_edge     | one edge
//  out     | output    | out_valid/out_ready, out_cyclic/input_error    | one result
//  cfg     | input     | cfg_valid/cfg_ready, cfg_data                  | vertex count
//
// An edge word is taken whenever in_valid is high in the load state. The word marked
// last starts a run: a clearing pass over all MAX_VERTICES entries of the visited map,
// then the walk: an edge read (ST_SCAN) and a visited read (ST_EDGE) per edge scanned,
// a decision (ST_VIS) when the edge touches the current vertex, and a stack read per pop
// (ST_POP), as set by the one read port of each memory. Input is held off in the run.
// Reset is synchronous, active low; memories are not reset.
// A pending result does not block loading of the next graph, only the end of its run.
module undirected_cycle_detector #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned MAX_EDGES    = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Edge input.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ucd_pkg::VID_W-1:0] in_edge_first,
  input  logic [ucd_pkg::VID_W-1:0] in_edge_second,
  input  logic                      in_last_edge,
  // Result output.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_cyclic,
  output logic                      out_input_error,
  // Vertex count register.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ucd_pkg::VCNT_W-1:0] cfg_data
);

  localparam int unsigned VW  = ucd_pkg::VID_W;
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned DW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned FW  = 2 * VW + 1 + ECW;

  typedef enum logic [2:0] {
    ST_LOAD, ST_CLEAR, ST_SCAN, ST_EDGE, ST_VIS, ST_POP, ST_FIN
  } state_t;

  state_t state_r;
  logic [ucd_pkg::VCNT_W-1:0] vcnt_r;
  logic [ECW-1:0] total_r;
  logic           drop_r;
  logic           err_r;
  logic           found_r;
  logic [VAW-1:0] clr_r;
  logic [DW-1:0]  depth_r;
  logic [VW-1:0]  vert_r;
  logic [VW-1:0]  pred_r;
  logic           has_pred_r;
  logic [ECW-1:0] pos_r;
  logic [VW-1:0]  nxt_r;
  logic           out_valid_r;
  logic           cyclic_r;
  logic           ierr_r;

  // Memory ports.
  logic           e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [2*VW-1:0] e_wdata, e_rdata;
  logic           v_we;
  logic [VAW-1:0] v_waddr, v_raddr;
  logic           v_wdata, v_rdata;
  logic           s_we;
  logic [VAW-1:0] s_waddr, s_raddr;
  logic [FW-1:0]  s_wdata, s_rdata;

  logic           in_acc;
  logic           edge_ok;
  logic [VW-1:0]  ea, eb, enxt;
  logic           ehit;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_cyclic = cyclic_r;
  assign out_input_error = ierr_r;

  // Edge is stored when both ends are below the count in use and below MAX_VERTICES and the store has room.
  assign edge_ok = (32'(in_edge_first)  < 32'(vcnt_r)) && (32'(in_edge_first)  < MAX_VERTICES)
                && (32'(in_edge_second) < 32'(vcnt_r)) && (32'(in_edge_second) < MAX_VERTICES)
                && (32'(total_r) < MAX_EDGES);

  // Neighbor of the current vertex on the edge just read.
  assign ea   = e_rdata[2*VW-1:VW];
  assign eb   = e_rdata[VW-1:0];
  assign ehit = (ea == vert_r) || (eb == vert_r);
  assign enxt = (ea == vert_r) ? eb : ea;

  // Memory port control.
  always_comb begin
    e_we    = in_acc && edge_ok;
    e_waddr = total_r[EAW-1:0];
    e_wdata = {in_edge_first, in_edge_second};
    e_raddr = pos_r[EAW-1:0];

    v_we    = 1'b0;
    v_waddr = clr_r;
    v_wdata = (clr_r == '0);
    v_raddr = VAW'(enxt);
    if (state_r == ST_CLEAR) begin
      v_we = 1'b1;
    end else if (state_r == ST_VIS && !v_rdata) begin
      v_we    = 1'b1;
      v_waddr = VAW'(nxt_r);
      v_wdata = 1'b1;
    end

    // Push saves the current top frame; pop reads the one below it.
    s_we    = (state_r == ST_VIS) && !v_rdata && (32'(depth_r) < MAX_VERTICES);
    s_waddr = VAW'(depth_r - DW'(1));
    s_wdata = {vert_r, pred_r, has_pred_r, pos_r};
    s_raddr = VAW'(depth_r - DW'(2));
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      vcnt_r      <= ucd_pkg::VCNT_RESET;
      total_r     <= '0;
      drop_r      <= 1'b0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vcnt_r <= cfg_data;
      end
      // The hand-over state sets the valid flag itself.
      if (out_valid_r && out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (edge_ok) begin
              total_r <= total_r + ECW'(1);
            end
            if (in_last_edge) begin
              err_r   <= drop_r || !edge_ok;
              drop_r  <= 1'b0;
              clr_r   <= '0;
              state_r <= ST_CLEAR;
            end else if (!edge_ok) begin
              drop_r <= 1'b1;
            end
          end
        end
        ST_CLEAR: begin
          clr_r <= clr_r + VAW'(1);
          if (clr_r == VAW'(MAX_VERTICES - 1)) begin
            vert_r     <= '0;
            pred_r     <= '0;
            has_pred_r <= 1'b0;
            pos_r      <= '0;
            depth_r    <= DW'(1);
            state_r    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pos_r >= total_r) begin
            if (depth_r == DW'(1)) begin
              found_r <= 1'b0;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_POP;
            end
          end else begin
            pos_r   <= pos_r + ECW'(1);
            state_r <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          nxt_r   <= enxt;
          state_r <= ehit ? ST_VIS : ST_SCAN;
        end
        ST_VIS: begin
          state_r <= ST_SCAN;
          if (!v_rdata) begin
            if (32'(depth_r) < MAX_VERTICES) begin
              vert_r     <= nxt_r;
              pred_r     <= vert_r;
              has_pred_r <= 1'b1;
              pos_r      <= '0;
              depth_r    <= depth_r + DW'(1);
            end
          end else if (!(has_pred_r && nxt_r == pred_r)) begin
            found_r <= 1'b1;
            state_r <= ST_FIN;
          end
        end
        ST_POP: begin
          {vert_r, pred_r, has_pred_r, pos_r} <= s_rdata;
          depth_r <= depth_r - DW'(1);
          state_r <= ST_SCAN;
        end
        ST_FIN: begin
          // Hand over the result once the output register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            cyclic_r    <= found_r;
            ierr_r      <= err_r;
            total_r     <= '0;
            depth_r     <= '0;
            state_r     <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  // Edge store.
  ucd_ram #(.WIDTH(2 * VW), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
    .rd_addr(e_raddr), .rd_data(e_rdata)
  );

  // Visited map.
  ucd_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited (
    .clk(clk), .wr_en(v_we), .wr_addr(v_waddr), .wr_data(v_wdata),
    .rd_addr(v_raddr), .rd_data(v_rdata)
  );

  // Walk stack, frames below the top.
  ucd_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
    .rd_addr(s_raddr), .rd_data(s_rdata)
  );

endmodule

FILE: test/ucd_cycle_check.sv
// Checker for the undirected cycle detector: watches the edge, result and vertex count
// channels, predicts each result and compares it. Depends on ucd_pkg.
module ucd_cycle_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [ucd_pkg::VID_W-1:0]   in_edge_first,
  input  logic [ucd_pkg::VID_W-1:0]   in_edge_second,
  input  logic                        in_last_edge,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_cyclic,
  input  logic                        out_input_error,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [ucd_pkg::VCNT_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          checked
);

  localparam int VMAX = 256;
  localparam int EMAX = 1024;

  typedef struct packed {
    logic cyclic;
    logic input_error;
  } verdict_t;

  logic [ucd_pkg::VCNT_W-1:0] vcount;
  logic [ucd_pkg::VID_W-1:0]  end_a [EMAX];
  logic [ucd_pkg::VID_W-1:0]  end_b [EMAX];
  int                stored;
  logic              dropped;
  verdict_t          verdicts[$];

  // Depth-first walk from vertex 0 over the stored edges, stopping at the first
  // visited neighbor that is not the predecessor.
  function automatic logic walk_finds_cycle();
    int   vert [VMAX];
    int   pred [VMAX];
    bit   has_pred [VMAX];
    int   pos [VMAX];
    bit   seen [VMAX];
    int   depth;
    int   top;
    int   nxt;
    logic found;
    found = 1'b0;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[0] = 1'b1;
    vert[0] = 0;
    pred[0] = 0;
    has_pred[0] = 1'b0;
    pos[0] = 0;
    depth = 1;
    while (depth > 0 && !found) begin
      top = depth - 1;
      if (pos[top] >= stored) begin
        depth--;
      end else begin
        nxt = -1;
        if (end_a[pos[top]] == vert[top]) nxt = end_b[pos[top]];
        else if (end_b[pos[top]] == vert[top]) nxt = end_a[pos[top]];
        pos[top]++;
        if (nxt >= 0) begin
          if (!seen[nxt]) begin
            seen[nxt] = 1'b1;
            if (depth < VMAX) begin
              vert[depth] = nxt;
              pred[depth] = vert[top];
              has_pred[depth] = 1'b1;
              pos[depth] = 0;
              depth++;
            end
          end else if (!(has_pred[top] && nxt == pred[top])) begin
            found = 1'b1;
          end
        end
      end
    end
    return found;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    checked = 0;
    pending = 0;
  end

  // Follow all three channels on each rising edge.
  always @(posedge clk) begin
    int       lim;
    verdict_t want;
    if (!rst_n) begin
      vcount = ucd_pkg::VCNT_RESET;
      stored = 0;
      dropped = 1'b0;
      verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) vcount = cfg_data;

      if (in_valid && in_ready) begin
        lim = (vcount < VMAX) ? vcount : VMAX;
        if (in_edge_first >= lim || in_edge_second >= lim || stored >= EMAX) begin
          dropped = 1'b1;
        end else begin
          end_a[stored] = in_edge_first;
          end_b[stored] = in_edge_second;
          stored++;
        end
        if (in_last_edge) begin
          want.cyclic = walk_finds_cycle();
          want.input_error = dropped;
          verdicts.push_back(want);
          stored = 0;
          dropped = 1'b0;
        end
      end

      if (out_valid && out_ready) begin
        checked++;
        if (verdicts.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = verdicts.pop_front();
          if (out_cyclic !== want.cyclic)
            report($sformatf("cyclic %b, expected %b", out_cyclic, want.cyclic));
          if (out_input_error !== want.input_error)
            report($sformatf("input_error %b, expected %b", out_input_error,
                             want.input_error));
        end
      end
    end
    pending = verdicts.size();
  end

endmodule

FILE: test/tb_undirected_cycle_detector.sv
// Testbench top for the undirected cycle detector: clock, reset, edge and vertex
// count stimulus, result back-pressure and verdict. Depends on ucd_pkg and ucd_cycle_check.
module tb_undirected_cycle_detector;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ucd_pkg::VID_W-1:0]  in_edge_first = '0;
  logic [ucd_pkg::VID_W-1:0]  in_edge_second = '0;
  logic              in_last_edge = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_cyclic;
  logic              out_input_error;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ucd_pkg::VCNT_W-1:0] cfg_data = '0;
  int                fail_count;
  int                pending;
  int                checked;

  bit                quiet = 1'b1;
  int                edges_sent = 0;
  int                graphs_sent = 0;
  int                vc_now = 256;

  undirected_cycle_detector uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_edge_first(in_edge_first),
    .in_edge_second(in_edge_second), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_ready(out_ready), .out_cyclic(out_cyclic),
    .out_input_error(out_input_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ucd_cycle_check checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_edge_first(in_edge_first),
    .in_edge_second(in_edge_second), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_ready(out_ready), .out_cyclic(out_cyclic),
    .out_input_error(out_input_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("FAIL undirected_cycle_detector");
    $finish;
  end

  // Result side: random stalls before each word, none while quiet.
  always begin
    int  stall;
    bit  seen;
    @(posedge clk);
    if (rst_n) begin
      stall = quiet ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        seen = out_valid;
        @(posedge clk);
      end while (!seen);
    end
  end

  // Sends one edge word, with a random gap before it, none while quiet.
  task automatic send_edge(input int a, input int b, input bit last);
    int gap;
    bit seen;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_edge_first <= a[ucd_pkg::VID_W-1:0];
    in_edge_second <= b[ucd_pkg::VID_W-1:0];
    in_last_edge <= last;
    do begin
      @(negedge clk);
      seen = in_ready;
      @(posedge clk);
    end while (!seen);
    edges_sent++;
    if (last) graphs_sent++;
  endtask

  // Writes the vertex count once all results are back and the block is idle.
  task automatic set_vertices(input int v);
    bit seen;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0 || !in_ready);
    @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v[ucd_pkg::VCNT_W-1:0];
    do begin
      @(negedge clk);
      seen = cfg_ready;
      @(posedge clk);
    end while (!seen);
    cfg_valid <= 1'b0;
    vc_now = v;
  endtask

  // Random graph over a small vertex span, mostly rooted at vertex 0, with some noise.
  task automatic send_random_graph();
    int n;
    int lim;
    int span;
    int a;
    int b;
    n = $urandom_range(1, 12);
    lim = (vc_now < 256) ? vc_now : 256;
    span = (lim < 2) ? 1 : $urandom_range(2, (lim < 16) ? lim : 16);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end else begin
        a = (i == 0 && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, span - 1);
        b = $urandom_range(0, span - 1);
      end
      send_edge(a, b, i == n - 1);
    end
  endtask

  initial begin
    int vc_list [9];
    int phase;
    vc_list = '{256, 1, 2, 0, 5, 511, 37, 300, 256};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed graphs at the reset vertex count.
    send_edge(0, 0, 1);                         // self-loop on the root
    send_edge(0, 1, 1);                         // single edge, no cycle
    send_edge(0, 1, 0); send_edge(1, 0, 1);     // parallel edges
    send_edge(0, 1, 0); send_edge(1, 2, 0); send_edge(2, 0, 1);
    send_edge(1, 2, 0); send_edge(2, 3, 0); send_edge(3, 1, 0);
    send_edge(0, 4, 1);                         // cycle away from the root
    send_edge(0, 255, 0); send_edge(255, 255, 1);
    send_edge(255, 0, 1);

    // Out-of-range endpoints, including a dropped last edge.
    set_vertices(10);
    send_edge(0, 9, 0); send_edge(10, 3, 0); send_edge(9, 0, 1);
    send_edge(0, 1, 0); send_edge(1, 0, 0); send_edge(1, 10, 1);

    // Nothing fits with no vertices.
    set_vertices(0);
    send_edge(0, 0, 1);

    // Overfull store: the first edge is a path start, the (2, 3) filler lies off the root, the last edge is dropped.
    set_vertices(511);
    quiet = 1'b1;
    send_edge(0, 1, 0);
    for (int i = 0; i < 1028; i++) send_edge(2, 3, 0);
    send_edge(1, 0, 1);

    // Random graphs through a series of vertex counts.
    phase = 0;
    while (edges_sent < 1700) begin
      set_vertices((phase < 9) ? vc_list[phase] : $urandom_range(0, 511));
      quiet = (phase % 3 == 0);
      for (int g = 0; g < 20 && edges_sent < 1700; g++) send_random_graph();
      phase++;
    end
    set_vertices(256);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("Covered %0d edges in %0d graphs over %0d vertex count settings.",
             edges_sent, graphs_sent, phase + 4);
    $display("Checked %0d result words.", checked);
    if (fail_count == 0) begin
      $display("PASS undirected_cycle_detector");
    end else begin
      $display("FAIL undirected_cycle_detector");
    end
    $finish;
  end

endmodule
